// ===== src/lps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lps_pkg
// shared constants and types for the line pixel stepper
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int COORD_BITS   = 12;
    localparam int DIM_BITS     = 12;
    localparam int COLOR_BITS   = 32;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [DIM_BITS-1:0]   FRAME_WIDTH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0]   FRAME_HEIGHT_RESET = DIM_BITS'(480);
    localparam logic [COLOR_BITS-1:0] LINE_COLOR_RESET   = '0;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_LINE_COLOR   = 2'd2
    } cfg_index_t;

    typedef enum logic {
        KIND_LOAD    = 1'b0,
        KIND_ADVANCE = 1'b1
    } kind_t;

endpackage
`default_nettype wire

// ===== src/lps_setup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lps_setup
// line setup: deltas, step directions and major axis from two endpoints
// ----------------------------------------------------------------------------
module lps_setup #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS
) (
    input  wire logic signed [COORD_BITS-1:0] x0,
    input  wire logic signed [COORD_BITS-1:0] y0,
    input  wire logic signed [COORD_BITS-1:0] x1,
    input  wire logic signed [COORD_BITS-1:0] y1,
    output logic             [COORD_BITS:0]   major_delta,
    output logic             [COORD_BITS:0]   minor_delta,
    output logic signed      [COORD_BITS-1:0] major_end,
    output logic                              major_is_x,
    output logic             [1:0]            step_signs
);

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic        [COORD_BITS:0] adx;
    logic        [COORD_BITS:0] ady;

    always_comb
    begin
        dx  = (COORD_BITS+1)'(x1) - (COORD_BITS+1)'(x0);
        dy  = (COORD_BITS+1)'(y1) - (COORD_BITS+1)'(y0);
        adx = dx[COORD_BITS] ? $unsigned(-dx) : $unsigned(dx);
        ady = dy[COORD_BITS] ? $unsigned(-dy) : $unsigned(dy);

        // bit 0: x steps up, bit 1: y steps up
        step_signs[0] = !dx[COORD_BITS] && (dx != '0);
        step_signs[1] = !dy[COORD_BITS] && (dy != '0);

        major_is_x = adx > ady;
        if (major_is_x)
        begin
            major_delta = adx;
            minor_delta = ady;
            major_end   = x1;
        end
        else
        begin
            major_delta = ady;
            minor_delta = adx;
            major_end   = y1;
        end
    end

endmodule
`default_nettype wire

// ===== src/line_pixel_stepper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// line_pixel_stepper
// integer line rasteriser, one pixel per advance command
// ----------------------------------------------------------------------------
// usage
//   command channel: a command is taken on a rising edge with start high and
//   busy low; busy stays low, so one command can be issued every cycle.
//   kind selects a line load (endpoints) or an advance (next pixel).
//   a load produces nothing; an advance on an active line produces one pixel
//   with colour, in-view flag and last marker; an advance with no active
//   line produces nothing.
//   a pixel passes through the command register and then the result register
//   after its advance transfer, and is marked on the result ports by result_valid.
//   throughput: one command per cycle, set by the single step of add,
//   compare and subtract on the error term between the command register and
//   the result register.
//   the receiver cannot stall; results must be taken as they appear.
//   configuration: cfg_valid/cfg_ready write channel (ready always high)
//   carrying a register index and data; write only while no command is
//   outstanding. indexes beyond the register list are ignored.
//   reset: no active line, frame 640 x 480, colour zero.
// ----------------------------------------------------------------------------
module line_pixel_stepper #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic                                  kind,
    input  wire logic signed [COORD_BITS-1:0]          start_x,
    input  wire logic signed [COORD_BITS-1:0]          start_y,
    input  wire logic signed [COORD_BITS-1:0]          end_x,
    input  wire logic signed [COORD_BITS-1:0]          end_y,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic        [lps_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic        [lps_pkg::COLOR_BITS-1:0]   cfg_data,
    output logic                                       result_valid,
    output logic signed      [COORD_BITS-1:0]          pixel_x,
    output logic signed      [COORD_BITS-1:0]          pixel_y,
    output logic                                       in_view,
    output logic             [lps_pkg::COLOR_BITS-1:0] pixel_color,
    output logic                                       last
);

    localparam int ERR_BITS = COORD_BITS + 2;
    localparam int CMP_BITS = COORD_BITS + lps_pkg::DIM_BITS;

    // configuration
    logic [lps_pkg::DIM_BITS-1:0]   frame_width_reg;
    logic [lps_pkg::DIM_BITS-1:0]   frame_height_reg;
    logic [lps_pkg::COLOR_BITS-1:0] line_color_reg;

    // command register
    logic                           cmd_valid_reg;
    logic                           cmd_kind_reg;
    logic signed [COORD_BITS-1:0]   cmd_x0_reg;
    logic signed [COORD_BITS-1:0]   cmd_y0_reg;
    logic signed [COORD_BITS-1:0]   cmd_x1_reg;
    logic signed [COORD_BITS-1:0]   cmd_y1_reg;

    // line state
    logic                           line_active_reg, line_active_next;
    logic signed [COORD_BITS-1:0]   cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0]   cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0]   major_end_reg, major_end_next;
    logic                           major_is_x_reg, major_is_x_next;
    logic [1:0]                     step_signs_reg, step_signs_next;
    logic [COORD_BITS:0]            major_delta_reg, major_delta_next;
    logic [COORD_BITS:0]            minor_delta_reg, minor_delta_next;
    logic signed [ERR_BITS-1:0]     error_reg, error_next;

    // result register
    logic                           res_valid_reg, res_valid_next;
    logic signed [COORD_BITS-1:0]   res_x_reg, res_x_next;
    logic signed [COORD_BITS-1:0]   res_y_reg, res_y_next;
    logic                           res_view_reg, res_view_next;
    logic [lps_pkg::COLOR_BITS-1:0] res_color_reg, res_color_next;
    logic                           res_last_reg, res_last_next;

    // setup results
    logic [COORD_BITS:0]            su_major_delta;
    logic [COORD_BITS:0]            su_minor_delta;
    logic signed [COORD_BITS-1:0]   su_major_end;
    logic                           su_major_is_x;
    logic [1:0]                     su_step_signs;

    // step terms
    logic signed [COORD_BITS-1:0]   step_x;
    logic signed [COORD_BITS-1:0]   step_y;
    logic signed [COORD_BITS-1:0]   major_pos;
    logic                           is_last;
    logic signed [ERR_BITS-1:0]     err_sum;
    logic signed [ERR_BITS:0]       err_twice;
    logic                           minor_step;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    lps_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .x0          (cmd_x0_reg),
        .y0          (cmd_y0_reg),
        .x1          (cmd_x1_reg),
        .y1          (cmd_y1_reg),
        .major_delta (su_major_delta),
        .minor_delta (su_minor_delta),
        .major_end   (su_major_end),
        .major_is_x  (su_major_is_x),
        .step_signs  (su_step_signs)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= lps_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= lps_pkg::FRAME_HEIGHT_RESET;
            line_color_reg   <= lps_pkg::LINE_COLOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lps_pkg::CFG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[lps_pkg::DIM_BITS-1:0];
                lps_pkg::CFG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[lps_pkg::DIM_BITS-1:0];
                lps_pkg::CFG_LINE_COLOR:
                    line_color_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // command capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_kind_reg <= kind;
            cmd_x0_reg   <= start_x;
            cmd_y0_reg   <= start_y;
            cmd_x1_reg   <= end_x;
            cmd_y1_reg   <= end_y;
        end
    end

    always_comb
    begin
        step_x    = step_signs_reg[0] ? COORD_BITS'(1) : '1;
        step_y    = step_signs_reg[1] ? COORD_BITS'(1) : '1;
        major_pos = major_is_x_reg ? cur_x_reg : cur_y_reg;
        is_last   = major_pos == major_end_reg;
        err_sum   = error_reg + $signed(ERR_BITS'(minor_delta_reg));
        err_twice = {err_sum, 1'b0};
        minor_step = err_twice >= $signed((ERR_BITS+1)'(major_delta_reg));

        line_active_next = line_active_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        major_end_next   = major_end_reg;
        major_is_x_next  = major_is_x_reg;
        step_signs_next  = step_signs_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        error_next       = error_reg;

        res_valid_next = 1'b0;
        res_x_next     = cur_x_reg;
        res_y_next     = cur_y_reg;
        res_view_next  = !cur_x_reg[COORD_BITS-1] && !cur_y_reg[COORD_BITS-1]
                      && (CMP_BITS'($unsigned(cur_x_reg)) < CMP_BITS'(frame_width_reg))
                      && (CMP_BITS'($unsigned(cur_y_reg)) < CMP_BITS'(frame_height_reg));
        res_color_next = line_color_reg;
        res_last_next  = is_last;

        if (cmd_valid_reg)
        begin
            case (lps_pkg::kind_t'(cmd_kind_reg))
                lps_pkg::KIND_LOAD:
                begin
                    line_active_next = 1'b1;
                    cur_x_next       = cmd_x0_reg;
                    cur_y_next       = cmd_y0_reg;
                    major_end_next   = su_major_end;
                    major_is_x_next  = su_major_is_x;
                    step_signs_next  = su_step_signs;
                    major_delta_next = su_major_delta;
                    minor_delta_next = su_minor_delta;
                    error_next       = '0;
                end
                lps_pkg::KIND_ADVANCE:
                begin
                    if (line_active_reg)
                    begin
                        res_valid_next = 1'b1;
                        if (is_last)
                        begin
                            line_active_next = 1'b0;
                        end
                        else
                        begin
                            error_next = minor_step
                                       ? err_sum - $signed(ERR_BITS'(major_delta_reg))
                                       : err_sum;
                            if (major_is_x_reg)
                            begin
                                cur_x_next = cur_x_reg + step_x;
                                if (minor_step)
                                    cur_y_next = cur_y_reg + step_y;
                            end
                            else
                            begin
                                cur_y_next = cur_y_reg + step_y;
                                if (minor_step)
                                    cur_x_next = cur_x_reg + step_x;
                            end
                        end
                    end
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            major_end_reg   <= '0;
            major_is_x_reg  <= 1'b0;
            step_signs_reg  <= '0;
            major_delta_reg <= '0;
            minor_delta_reg <= '0;
            error_reg       <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            line_active_reg <= line_active_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            major_end_reg   <= major_end_next;
            major_is_x_reg  <= major_is_x_next;
            step_signs_reg  <= step_signs_next;
            major_delta_reg <= major_delta_next;
            minor_delta_reg <= minor_delta_next;
            error_reg       <= error_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        res_view_reg  <= res_view_next;
        res_color_reg <= res_color_next;
        res_last_reg  <= res_last_next;
    end

    assign result_valid = res_valid_reg;
    assign pixel_x      = res_x_reg;
    assign pixel_y      = res_y_reg;
    assign in_view      = res_view_reg;
    assign pixel_color  = res_color_reg;
    assign last         = res_last_reg;

`ifndef SYNTHESIS
    a_result_from_command: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, 2))
        else $error("result without a command two cycles earlier");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last && !cmd_valid_reg) |-> !line_active_reg)
        else $error("line still active after its last pixel");

    a_error_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |->
            ($signed({error_reg, 1'b0}) <= $signed((ERR_BITS+1)'(major_delta_reg))) &&
            ($signed({error_reg, 1'b0}) >= -$signed((ERR_BITS+1)'(major_delta_reg))))
        else $error("error term outside half the major delta");
`endif

endmodule
`default_nettype wire
